@@ design/trd_pkg.sv @@
// shared constants and types for the tail repetition detector
`default_nettype none

package trd_pkg;

	localparam int DEPTH       = 64;
	localparam int ENTRY_BITS  = 32;
	localparam int ADDR_BITS   = $clog2(DEPTH);
	localparam int COUNT_BITS  = ADDR_BITS + 1;
	localparam int MIN_ENTRIES = 4;
	localparam int MIN_WINDOW  = 2;

	localparam int LEN_BITS   = 6;
	localparam int REPS_BITS  = 5;
	localparam int HCNT_BITS  = 7;
	localparam int ODATA_BITS = 24;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_WINDOW,
		ST_ISSUE,
		ST_CHECK,
		ST_FINISH,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

@@ design/tail_repetition_detector.sv @@
// top level of the tail repetition detector: history memory and scan sequencer
`default_nettype none

// usage
//   slave side: one transaction per item. s_tuser is the operation (append or
//   clear), s_tdata the entry word. the block takes an item only while its
//   scan sequencer is idle, so items are handled one at a time.
//   master side: one transaction per item with the loop report.
// sequencing
//   an item passes through idle, start, the scan and the report state. the
//   scan walks window sizes from count/2 down to 2 and stops at the first
//   one that repeats; each window compares its entries one by one, one
//   pair of history reads per compare through the two-read-port memory.
// reset
//   clears the entry count, the oldest pointer and the sequencer; the history
//   memory is not cleared, only written slots are ever read.
// stalls
//   a finished report sits in the output register; the next item is taken
//   while it waits, and that item's report waits until the register drains,
//   holding off further input meanwhile.
module tail_repetition_detector (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	input  wire  [trd_pkg::ENTRY_BITS-1:0]      s_tdata,  // entry
	input  wire                                 s_tuser,  // operation
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [trd_pkg::ODATA_BITS-1:0]      m_tdata,  // loop_length, repetitions, history_count
	output logic                                m_tuser   // found
);
	import trd_pkg::*;

	state_t state_q, state_d;

	// history memory, two registered read ports
	logic [ENTRY_BITS-1:0] mem [DEPTH];
	logic [ENTRY_BITS-1:0] rd_a_q, rd_b_q;

	logic [COUNT_BITS-1:0] cnt_q;
	logic [ADDR_BITS-1:0]  oldest_q;

	// scan registers: window size, compared block start, offset, repetitions
	logic [COUNT_BITS-1:0] w_q;
	logic [COUNT_BITS-1:0] start_q;
	logic [COUNT_BITS-1:0] k_q;
	logic [COUNT_BITS-1:0] reps_q;

	logic                  out_valid_q;
	logic                  out_found_q;
	logic [LEN_BITS-1:0]   out_len_q;
	logic [REPS_BITS-1:0]  out_reps_q;
	logic [HCNT_BITS-1:0]  out_count_q;

	logic                  in_acc;
	logic                  out_free;
	logic [COUNT_BITS-1:0] tail;
	logic [COUNT_BITS-1:0] wr_sum, a_sum, b_sum;
	logic [ADDR_BITS-1:0]  wr_addr, rd_a_addr, rd_b_addr;
	logic                  is_match, last_k, more_blocks, found_now;

	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign tail     = cnt_q - w_q;

	// when full, oldest + count wraps onto the oldest slot itself
	assign wr_sum  = {1'b0, oldest_q} + cnt_q;
	assign wr_addr = wr_sum[ADDR_BITS-1:0];
	assign a_sum     = {1'b0, oldest_q} + start_q + k_q;
	assign b_sum     = {1'b0, oldest_q} + tail + k_q;
	assign rd_a_addr = a_sum[ADDR_BITS-1:0];
	assign rd_b_addr = b_sum[ADDR_BITS-1:0];

	assign is_match    = (rd_a_q == rd_b_q);
	assign last_k      = (k_q == w_q - COUNT_BITS'(1));
	assign more_blocks = (start_q >= w_q);
	assign found_now   = (reps_q != '0);

	// memory: write on append, read during issue
	always_ff @(posedge clk) begin
		if (in_acc && s_tuser == OP_APPEND) begin
			mem[wr_addr] <= s_tdata;
		end
		if (state_q == ST_ISSUE) begin
			rd_a_q <= mem[rd_a_addr];
			rd_b_q <= mem[rd_b_addr];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_START;
			end
			ST_START: begin
				if (cnt_q < COUNT_BITS'(MIN_ENTRIES)) state_d = ST_DONE;
				else state_d = ST_WINDOW;
			end
			ST_WINDOW: state_d = ST_ISSUE;
			ST_ISSUE:  state_d = ST_CHECK;
			ST_CHECK: begin
				if (!is_match) state_d = ST_FINISH;
				else if (!last_k) state_d = ST_ISSUE;
				else if (more_blocks) state_d = ST_ISSUE;
				else state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (found_now || w_q == COUNT_BITS'(MIN_WINDOW)) state_d = ST_DONE;
				else state_d = ST_WINDOW;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		m_tvalid = out_valid_q;
		m_tuser  = out_found_q;
		m_tdata  = {(ODATA_BITS - LEN_BITS - REPS_BITS - HCNT_BITS)'(0),
			out_count_q, out_reps_q, out_len_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			oldest_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				if (s_tuser == OP_CLEAR) begin
					cnt_q    <= '0;
					oldest_q <= '0;
				end else if (cnt_q < COUNT_BITS'(DEPTH)) begin
					cnt_q <= cnt_q + COUNT_BITS'(1);
				end else begin
					oldest_q <= oldest_q + ADDR_BITS'(1);
				end
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// scan datapath and report register
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_START: begin
				w_q    <= cnt_q >> 1;
				reps_q <= '0;
			end
			ST_WINDOW: begin
				start_q <= tail - w_q;
				k_q     <= '0;
				reps_q  <= '0;
			end
			ST_CHECK: begin
				if (is_match) begin
					if (last_k) begin
						reps_q <= reps_q + COUNT_BITS'(1);
						k_q    <= '0;
						if (more_blocks) start_q <= start_q - w_q;
					end else begin
						k_q <= k_q + COUNT_BITS'(1);
					end
				end
			end
			ST_FINISH: begin
				if (!(found_now || w_q == COUNT_BITS'(MIN_WINDOW))) w_q <= w_q - COUNT_BITS'(1);
			end
			ST_DONE: begin
				if (out_free) begin
					out_found_q <= found_now;
					if (!found_now) out_len_q <= '0;
					else if (w_q > COUNT_BITS'((1 << LEN_BITS) - 1)) out_len_q <= '1;
					else out_len_q <= LEN_BITS'(w_q);
					if (reps_q > COUNT_BITS'((1 << REPS_BITS) - 1)) out_reps_q <= '1;
					else out_reps_q <= REPS_BITS'(reps_q);
					if (cnt_q > COUNT_BITS'((1 << HCNT_BITS) - 1)) out_count_q <= '1;
					else out_count_q <= HCNT_BITS'(cnt_q);
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= COUNT_BITS'(DEPTH))
		else $error("history count beyond depth");

	a_found_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == (m_tdata[LEN_BITS-1:0] != '0)))
		else $error("found flag disagrees with loop length");

	a_len_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |->
		({2'b00, m_tdata[LEN_BITS-1:0]} <=
		{1'b0, m_tdata[LEN_BITS+REPS_BITS+HCNT_BITS-1:LEN_BITS+REPS_BITS]} >> 1))
		else $error("loop length above half the history");

	a_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE) |-> (k_q < w_q && tail >= w_q))
		else $error("scan offset outside window");

	a_append_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_tuser == OP_APPEND) |=> (cnt_q != '0))
		else $error("append left history empty");
`endif

endmodule

`default_nettype wire
